>>> sv/isf_pkg.sv
// shared types, constants and arithmetic helpers of the image size fit calculator
// no dependencies; every other file imports this package
package isf_pkg;

    localparam int DIM_BITS       = 17;
    localparam int ZOOM_FRAC_BITS = 16;
    localparam int ZOOM_BITS      = ZOOM_FRAC_BITS + 8;
    localparam int MAG_BITS       = DIM_BITS - 1;
    localparam int ZPROD_W        = ZOOM_BITS + MAG_BITS;
    localparam int XPROD_W        = 2 * DIM_BITS;
    localparam int NUM_W          = 2 * DIM_BITS;
    localparam int DEN_W          = DIM_BITS;
    localparam int NSUM_W         = XPROD_W + 2;
    localparam int RES_W          = NUM_W + 1;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = (ZOOM_BITS > DIM_BITS) ? ZOOM_BITS : DIM_BITS;
    localparam int TDATA_W        = ((2 * DIM_BITS + 7) / 8) * 8;

    localparam logic signed [DIM_BITS-1:0] DIM_MAX     = {1'b0, {MAG_BITS{1'b1}}};
    localparam logic signed [DIM_BITS-1:0] DIM_MIN     = {1'b1, {MAG_BITS{1'b0}}};
    localparam logic signed [DIM_BITS-1:0] BOUND_UNSET = '1;
    localparam logic signed [RES_W-1:0]    RES_MAX     = RES_W'(DIM_MAX);
    localparam logic signed [RES_W-1:0]    RES_MIN     = RES_W'(DIM_MIN);
    localparam logic [ZOOM_BITS-1:0]       ZOOM_ONE    = ZOOM_BITS'(1) << ZOOM_FRAC_BITS;
    localparam logic [ZPROD_W:0]           ZOOM_HALF   = (ZPROD_W + 1)'(1) << (ZOOM_FRAC_BITS - 1);
    localparam logic [ZPROD_W:0]           ZOOM_SAT    = (ZPROD_W + 1)'(DIM_MAX);

    typedef enum logic [1:0] {
        MODE_ZOOM     = 2'd0,
        MODE_ZOOM_MAX = 2'd1,
        MODE_FIT      = 2'd2,
        MODE_FIXED    = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SIZE_MODE   = 3'd0,
        REG_ZOOM_X      = 3'd1,
        REG_ZOOM_Y      = 3'd2,
        REG_BOUND_W     = 3'd3,
        REG_BOUND_H     = 3'd4,
        REG_KEEP_ASPECT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_mode                        mode;
        logic [ZOOM_BITS-1:0]         zoom_x;
        logic [ZOOM_BITS-1:0]         zoom_y;
        logic signed [DIM_BITS-1:0]   bound_w;
        logic signed [DIM_BITS-1:0]   bound_h;
        logic                         keep_aspect;
    } t_cfg;

    // sideband that rides along the divider pipelines
    typedef struct packed {
        logic signed [DIM_BITS-1:0] iw;
        logic signed [DIM_BITS-1:0] ih;
        logic signed [DIM_BITS-1:0] w;
        logic signed [DIM_BITS-1:0] h;
        logic                       skip;
        logic                       fault;
        logic                       use_div;
        logic                       neg0;
        logic                       neg1;
    } t_side;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } t_dstep;

    // one restoring division step, quotient bits shift in at the bottom
    function automatic t_dstep div_step(input logic [DEN_W-1:0] rem,
                                        input logic [NUM_W-1:0] nq,
                                        input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t_dstep         s;
        t = {rem, nq[NUM_W-1]};
        if (t >= {1'b0, den}) begin
            s.rem = DEN_W'(t - {1'b0, den});
            s.nq  = {nq[NUM_W-2:0], 1'b1};
        end else begin
            s.rem = t[DEN_W-1:0];
            s.nq  = {nq[NUM_W-2:0], 1'b0};
        end
        return s;
    endfunction

    function automatic logic signed [DIM_BITS-1:0] zoom_round(input logic [ZPROD_W-1:0] p);
        logic [ZPROD_W:0] s;
        s = ({1'b0, p} + ZOOM_HALF) >> ZOOM_FRAC_BITS;
        if (s > ZOOM_SAT) begin
            return DIM_MAX;
        end
        return s[DIM_BITS-1:0];
    endfunction

    function automatic logic signed [DIM_BITS-1:0] sat_dim(input logic signed [RES_W-1:0] v);
        if (v > RES_MAX) begin
            return DIM_MAX;
        end
        if (v < RES_MIN) begin
            return DIM_MIN;
        end
        return v[DIM_BITS-1:0];
    endfunction

    // magnitude and sign back to a signed value, up adds one before negation
    function automatic logic signed [RES_W-1:0] apply_sign(input logic [NUM_W-1:0] q,
                                                          input logic up,
                                                          input logic neg);
        logic [RES_W-1:0] mag;
        mag = {1'b0, q} + RES_W'(up);
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

    function automatic logic [NUM_W-1:0] mag_prod(input logic [XPROD_W-1:0] v);
        logic [XPROD_W-1:0] m;
        m = v[XPROD_W-1] ? -v : v;
        return NUM_W'(m);
    endfunction

    function automatic logic [NUM_W-1:0] mag_sum(input logic [NSUM_W-1:0] v);
        logic [NSUM_W-1:0] m;
        m = v[NSUM_W-1] ? -v : v;
        return m[NUM_W-1:0];
    endfunction

    function automatic logic [DEN_W-1:0] mag_dim(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS-1:0] m;
        m = v[DIM_BITS-1] ? -v : v;
        return DEN_W'(m);
    endfunction

endpackage

>>> sv/image_size_fit_calculator_top.sv
// top level of the image size fit calculator: zoom, bound ratio and aspect pipeline
// depends on isf_pkg, isf_cfg and isf_div2
//
//  port group   dir  beat contents
//  i_s_axis_*   in   tdata: src_width, src_height
//  o_m_axis_*   out  tdata: out_width, out_height; tuser: divide_fault
//  i_cfg_*      in   register index and write data, one write per cycle
//
// one beat enters per cycle unless the output stalls; the two dividers in the path
// each resolve one quotient bit per stage.
// reset clears all valid bits and loads the register defaults.
// a stall at the output freezes every stage at once; nothing is dropped or repeated.
module image_size_fit_calculator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [isf_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [isf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [isf_pkg::TDATA_W-1:0]      i_s_axis_tdata,  // src_width, src_height
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [isf_pkg::TDATA_W-1:0]      o_m_axis_tdata,  // out_width, out_height
    output logic [0:0]                       o_m_axis_tuser   // divide_fault
);
    import isf_pkg::*;

    t_cfg cfg;
    logic adv;

    isf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    logic                      r_out_v;
    logic signed [DIM_BITS-1:0] r_out_w, r_out_h;
    logic                      r_out_fault;

    assign adv             = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = adv;

    // stage 1: capture and zoom products
    logic                       r1_v;
    logic signed [DIM_BITS-1:0] r1_iw, r1_ih;
    logic [ZPROD_W-1:0]         r1_zpw, r1_zph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_iw  <= i_s_axis_tdata[DIM_BITS-1:0];
            r1_ih  <= i_s_axis_tdata[2*DIM_BITS-1:DIM_BITS];
            r1_zpw <= cfg.zoom_x * i_s_axis_tdata[MAG_BITS-1:0];
            r1_zph <= cfg.zoom_y * i_s_axis_tdata[DIM_BITS+MAG_BITS-1:DIM_BITS];
        end
    end

    // stage 2: rounded zoom (source size in fit mode), cross products for the ratio compare
    logic signed [DIM_BITS-1:0] n2_a, n2_b;
    logic                       r2_v;
    logic signed [DIM_BITS-1:0] r2_iw, r2_ih, r2_a, r2_b;
    logic signed [XPROD_W-1:0]  r2_x1, r2_x2;

    always_comb begin
        if (cfg.mode == MODE_FIT) begin
            n2_a = r1_iw;
            n2_b = r1_ih;
        end else begin
            n2_a = zoom_round(r1_zpw);
            n2_b = zoom_round(r1_zph);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_iw <= r1_iw;
            r2_ih <= r1_ih;
            r2_a  <= n2_a;
            r2_b  <= n2_b;
            r2_x1 <= cfg.bound_w * n2_b;
            r2_x2 <= cfg.bound_h * n2_a;
        end
    end

    // stage 3: mode decision, pick ratio p/q, numerator products
    t_side                      n3_side;
    logic signed [DIM_BITS-1:0] n3_p, n3_q;
    logic                       n3_lt, n3_shrink;
    logic                       r3_v;
    t_side                      r3_side;
    logic signed [XPROD_W-1:0]  r3_pa, r3_pb;
    logic [DIM_BITS-1:0]        r3_q;

    always_comb begin
        n3_side         = '0;
        n3_side.iw      = r2_iw;
        n3_side.ih      = r2_ih;
        n3_side.w       = r2_a;
        n3_side.h       = r2_b;
        n3_side.skip    = (cfg.mode != MODE_FIXED) &&
                          (r2_iw[DIM_BITS-1] || r2_ih[DIM_BITS-1]);
        n3_p            = cfg.bound_h;
        n3_q            = r2_b;
        n3_lt           = r2_x1 < r2_x2;
        n3_shrink       = (r2_a > cfg.bound_w) || (r2_b > cfg.bound_h);
        unique case (cfg.mode)
            MODE_ZOOM: ;
            MODE_ZOOM_MAX: begin
                if (n3_shrink) begin
                    if (r2_a == '0 || r2_b == '0) begin
                        n3_side.fault = 1'b1;
                    end else begin
                        n3_side.use_div = 1'b1;
                    end
                end
                if (n3_lt) begin
                    n3_p = cfg.bound_w;
                    n3_q = r2_a;
                end
            end
            MODE_FIT: begin
                if (r2_iw == '0 || r2_ih == '0) begin
                    n3_side.fault = 1'b1;
                end else begin
                    n3_side.use_div = 1'b1;
                end
                // an unset (negative) bound yields to the other one
                priority if (cfg.bound_w[DIM_BITS-1]) begin
                    n3_p = cfg.bound_h;
                    n3_q = r2_b;
                end else if (cfg.bound_h[DIM_BITS-1]) begin
                    n3_p = cfg.bound_w;
                    n3_q = r2_a;
                end else if (n3_lt) begin
                    n3_p = cfg.bound_w;
                    n3_q = r2_a;
                end
            end
            MODE_FIXED: begin
                if (cfg.bound_w != BOUND_UNSET) begin
                    n3_side.w = cfg.bound_w;
                end else begin
                    n3_side.w = r2_iw;
                end
                if (cfg.bound_h != BOUND_UNSET) begin
                    n3_side.h = cfg.bound_h;
                end else begin
                    n3_side.h = r2_ih;
                end
            end
        endcase
        if (n3_side.skip) begin
            n3_side.w       = r2_iw;
            n3_side.h       = r2_ih;
            n3_side.fault   = 1'b0;
            n3_side.use_div = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_side <= n3_side;
            r3_pa   <= n3_p * r2_a;
            r3_pb   <= n3_p * r2_b;
            r3_q    <= n3_q;
        end
    end

    // stage 4: numerators 2*p*s + q over 2*q, split into sign and magnitude
    logic [NSUM_W-1:0] n4_n0, n4_n1;
    t_side             n4_side;
    logic [DEN_W-1:0]  n4_den;

    always_comb begin
        n4_n0        = {r3_pa[XPROD_W-1], r3_pa, 1'b0} + NSUM_W'(r3_q);
        n4_n1        = {r3_pb[XPROD_W-1], r3_pb, 1'b0} + NSUM_W'(r3_q);
        n4_den       = DEN_W'({r3_q[DIM_BITS-2:0], 1'b0});
        n4_side      = r3_side;
        n4_side.neg0 = n4_n0[NSUM_W-1];
        n4_side.neg1 = n4_n1[NSUM_W-1];
    end

    logic             d1_v;
    t_side            d1_side;
    logic [NUM_W-1:0] d1_q0, d1_q1;
    logic             d1_r0, d1_r1;

    isf_div2 u_div_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r3_v),
        .i_side  (n4_side),
        .i_num0  (mag_sum(n4_n0)),
        .i_den0  (n4_den),
        .i_num1  (mag_sum(n4_n1)),
        .i_den1  (n4_den),
        .o_valid (d1_v),
        .o_side  (d1_side),
        .o_quo0  (d1_q0),
        .o_rnz0  (d1_r0),
        .o_quo1  (d1_q1),
        .o_rnz1  (d1_r1)
    );

    // stage 5: floor the scaled sides, saturate, mode result
    t_side n5_side;
    logic  r5_v;
    t_side r5_side;

    always_comb begin
        n5_side = d1_side;
        if (d1_side.use_div) begin
            n5_side.w = sat_dim(apply_sign(d1_q0, d1_r0 & d1_side.neg0, d1_side.neg0));
            n5_side.h = sat_dim(apply_sign(d1_q1, d1_r1 & d1_side.neg1, d1_side.neg1));
        end
        // use_div now marks the aspect step
        n5_side.use_div = !d1_side.skip && !d1_side.fault && cfg.keep_aspect;
        n5_side.neg0    = 1'b0;
        n5_side.neg1    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_side <= n5_side;
        end
    end

    // stage 6: aspect products and zero divisor check
    t_side                     n6_side;
    logic                      n6_afault;
    logic                      r6_v;
    t_side                     r6_side;
    logic signed [XPROD_W-1:0] r6_m0, r6_m1;

    always_comb begin
        n6_side   = r5_side;
        n6_afault = r5_side.use_div &&
                    ((r5_side.w <= r5_side.h) ? (r5_side.iw == '0) : (r5_side.ih == '0));
        n6_side.fault   = r5_side.fault || n6_afault;
        n6_side.use_div = r5_side.use_div && !n6_afault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_side <= n6_side;
            r6_m0   <= r5_side.ih * r5_side.w;
            r6_m1   <= r5_side.iw * r5_side.h;
        end
    end

    // stage 7: truncating divisions, both candidates computed
    t_side n7_side;

    always_comb begin
        n7_side      = r6_side;
        n7_side.neg0 = r6_m0[XPROD_W-1] ^ r6_side.iw[DIM_BITS-1];
        n7_side.neg1 = r6_m1[XPROD_W-1] ^ r6_side.ih[DIM_BITS-1];
    end

    logic             d2_v;
    t_side            d2_side;
    logic [NUM_W-1:0] d2_q0, d2_q1;
    logic             d2_r0, d2_r1;

    isf_div2 u_div_aspect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r6_v),
        .i_side  (n7_side),
        .i_num0  (mag_prod(r6_m0)),
        .i_den0  (mag_dim(r6_side.iw)),
        .i_num1  (mag_prod(r6_m1)),
        .i_den1  (mag_dim(r6_side.ih)),
        .o_valid (d2_v),
        .o_side  (d2_side),
        .o_quo0  (d2_q0),
        .o_rnz0  (d2_r0),
        .o_quo1  (d2_q1),
        .o_rnz1  (d2_r1)
    );

    // stage 8: final selection into the output register
    logic signed [DIM_BITS-1:0] n8_w, n8_h;

    always_comb begin
        priority if (d2_side.fault) begin
            n8_w = d2_side.iw;
            n8_h = d2_side.ih;
        end else if (d2_side.use_div && (d2_side.w <= d2_side.h)) begin
            n8_w = d2_side.w;
            n8_h = sat_dim(apply_sign(d2_q0, 1'b0, d2_side.neg0));
        end else if (d2_side.use_div) begin
            n8_w = sat_dim(apply_sign(d2_q1, 1'b0, d2_side.neg1));
            n8_h = d2_side.h;
        end else begin
            n8_w = d2_side.w;
            n8_h = d2_side.h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_w     <= n8_w;
            r_out_h     <= n8_h;
            r_out_fault <= d2_side.fault;
        end
    end

    assign o_m_axis_tvalid   = r_out_v;
    assign o_m_axis_tdata    = TDATA_W'({r_out_h, r_out_w});
    assign o_m_axis_tuser[0] = r_out_fault;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r1_v)
        else $error("accepted beat did not enter stage 1");

    a_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && r3_side.skip) |-> (!r3_side.fault && !r3_side.use_div))
        else $error("skipped beat flagged for fault or division");

    a_aspect_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_v && r6_side.use_div) |-> !r6_side.fault)
        else $error("aspect division scheduled on a faulted beat");

endmodule

>>> sv/isf_cfg.sv
// configuration register file of the image size fit calculator
// depends on isf_pkg
module isf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [isf_pkg::CFG_ADDR_W-1:0]   i_addr,
    input  logic [isf_pkg::CFG_DATA_W-1:0]   i_wdata,
    output isf_pkg::t_cfg                    o_cfg
);
    import isf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_ZOOM;
            r_cfg.zoom_x      <= ZOOM_ONE;
            r_cfg.zoom_y      <= ZOOM_ONE;
            r_cfg.bound_w     <= BOUND_UNSET;
            r_cfg.bound_h     <= BOUND_UNSET;
            r_cfg.keep_aspect <= 1'b0;
        end else if (i_we) begin
            unique case (t_reg_idx'(i_addr))
                REG_SIZE_MODE:   r_cfg.mode        <= t_mode'(i_wdata[1:0]);
                REG_ZOOM_X:      r_cfg.zoom_x      <= i_wdata[ZOOM_BITS-1:0];
                REG_ZOOM_Y:      r_cfg.zoom_y      <= i_wdata[ZOOM_BITS-1:0];
                REG_BOUND_W:     r_cfg.bound_w     <= i_wdata[DIM_BITS-1:0];
                REG_BOUND_H:     r_cfg.bound_h     <= i_wdata[DIM_BITS-1:0];
                REG_KEEP_ASPECT: r_cfg.keep_aspect <= i_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/isf_div2.sv
// two-lane pipelined restoring divider, one quotient bit per stage, with sideband
// depends on isf_pkg
module isf_div2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  isf_pkg::t_side                i_side,
    input  logic [isf_pkg::NUM_W-1:0]     i_num0,
    input  logic [isf_pkg::DEN_W-1:0]     i_den0,
    input  logic [isf_pkg::NUM_W-1:0]     i_num1,
    input  logic [isf_pkg::DEN_W-1:0]     i_den1,
    output logic                          o_valid,
    output isf_pkg::t_side                o_side,
    output logic [isf_pkg::NUM_W-1:0]     o_quo0,
    output logic                          o_rnz0,
    output logic [isf_pkg::NUM_W-1:0]     o_quo1,
    output logic                          o_rnz1
);
    import isf_pkg::*;

    logic             r_v    [0:NUM_W];
    t_side            r_side [0:NUM_W];
    logic [NUM_W-1:0] r_nq0  [0:NUM_W];
    logic [NUM_W-1:0] r_nq1  [0:NUM_W];
    logic [DEN_W-1:0] r_rem0 [0:NUM_W];
    logic [DEN_W-1:0] r_rem1 [0:NUM_W];
    logic [DEN_W-1:0] r_den0 [0:NUM_W];
    logic [DEN_W-1:0] r_den1 [0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_nq0[0]  <= i_num0;
            r_nq1[0]  <= i_num1;
            r_rem0[0] <= '0;
            r_rem1[0] <= '0;
            r_den0[0] <= i_den0;
            r_den1[0] <= i_den1;
        end
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        t_dstep n_s0;
        t_dstep n_s1;

        assign n_s0 = div_step(r_rem0[k-1], r_nq0[k-1], r_den0[k-1]);
        assign n_s1 = div_step(r_rem1[k-1], r_nq1[k-1], r_den1[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= r_side[k-1];
                r_nq0[k]  <= n_s0.nq;
                r_nq1[k]  <= n_s1.nq;
                r_rem0[k] <= n_s0.rem;
                r_rem1[k] <= n_s1.rem;
                r_den0[k] <= r_den0[k-1];
                r_den1[k] <= r_den1[k-1];
            end
        end
    end

    assign o_valid = r_v[NUM_W];
    assign o_side  = r_side[NUM_W];
    assign o_quo0  = r_nq0[NUM_W];
    assign o_quo1  = r_nq1[NUM_W];
    assign o_rnz0  = |r_rem0[NUM_W];
    assign o_rnz1  = |r_rem1[NUM_W];

endmodule
